>>> rtl/core/cd_read_toc_responder_assert.svh
// Assertion macros shared by the READ TOC responder RTL.
// Needs nothing; the including module supplies clock, reset and operands.
`ifndef CD_READ_TOC_RESPONDER_ASSERT_SVH
`define CD_READ_TOC_RESPONDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CRT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/crt_pkg.sv
// Shared types and constants of the READ TOC responder.
// No dependencies; every other RTL file but the assertion header uses this package.
`default_nettype none
package crt_pkg;

   // Field widths of the command, response and register file.
   localparam int TOC_BYTES  = 12;
   localparam int TRACK_W    = 8;
   localparam int ALLOC_W    = 16;
   localparam int BYTE_W     = 8;
   localparam int STATUS_W   = 2;
   localparam int BLOCK_W    = 21;
   localparam int ADDR_W     = BLOCK_W + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = BLOCK_W;
   localparam int IDX_W      = $clog2(TOC_BYTES);
   localparam int CNT_W      = $clog2(TOC_BYTES + 1);

   // Command queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Track numbers and table contents.
   localparam logic [TRACK_W-1:0] TRACK_ALL     = 8'h00;
   localparam logic [TRACK_W-1:0] TRACK_DATA    = 8'h01;
   localparam logic [TRACK_W-1:0] TRACK_LEADOUT = 8'hAA;
   localparam logic [BYTE_W-1:0]  TOC_LENGTH    = 8'd10;
   localparam logic [BYTE_W-1:0]  CTRL_DATA     = 8'h14;

   // MSF conversion: 75 frames a second, 60 seconds a minute, 2 second base.
   localparam int FRAMES_PER_SEC = 75;
   localparam int SECS_PER_MIN   = 60;
   localparam int MSF_BASE       = 2 * FRAMES_PER_SEC;

   // Reciprocals for the constant divisions; exact over the address range.
   localparam int DIV75_SHIFT = 29;
   localparam int DIV75_MUL_W = 23;
   localparam logic [DIV75_MUL_W-1:0] DIV75_MUL =
      DIV75_MUL_W'((2 ** DIV75_SHIFT + FRAMES_PER_SEC - 1) / FRAMES_PER_SEC);
   localparam int Q75_W       = 16;
   localparam int DIV60_SHIFT = 21;
   localparam int DIV60_MUL_W = 16;
   localparam logic [DIV60_MUL_W-1:0] DIV60_MUL =
      DIV60_MUL_W'((2 ** DIV60_SHIFT + SECS_PER_MIN - 1) / SECS_PER_MIN);

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_UNIT_READY   = 2'd0,
      CSR_TRACK_SET_UP = 2'd1,
      CSR_FIRST_BLOCK  = 2'd2,
      CSR_FINAL_BLOCK  = 2'd3
   } csr_index_type;

   // Completion status of a command.
   typedef enum logic [STATUS_W-1:0] {
      ST_GOOD      = 2'd0,
      ST_NOT_READY = 2'd1,
      ST_BAD_FIELD = 2'd2
   } status_type;

   // One classified command as it travels through the queue.
   typedef struct packed {
      status_type         status;
      logic               empty;    // answer is a single item without a byte
      logic               msf;
      logic               leadout;
      logic [CNT_W-1:0]   count;
      logic [ADDR_W-1:0]  value;    // block address, or frame count in MSF form
   } cmd_type;

   // Queue fill status seen by both sides.
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // Back-end status for checking.
   typedef struct packed {
      logic busy;
      logic emit;
      logic last;
      logic msf;
      logic addr_byte;
      logic conv_ready;
   } back_mon_type;

endpackage
`default_nettype wire

>>> rtl/core/crt_channels.sv
// Handshake channels of the READ TOC responder: command in, response out.
// Depends on crt_pkg for field widths.
`default_nettype none
interface crt_req_if;
   logic                          valid;
   logic                          ready;
   logic                          msf_format;
   logic [crt_pkg::TRACK_W-1:0]   track_requested;
   logic [crt_pkg::ALLOC_W-1:0]   alloc_length;

   modport source (output valid, msf_format, track_requested, alloc_length,
                   input ready);
   modport sink   (input valid, msf_format, track_requested, alloc_length,
                   output ready);
endinterface

interface crt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [crt_pkg::BYTE_W-1:0]    data_byte;
   logic                          last;
   logic [crt_pkg::STATUS_W-1:0]  status;
   logic                          no_data;

   modport source (output valid, data_byte, last, status, no_data, input ready);
   modport sink   (input valid, data_byte, last, status, no_data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/cd_read_toc_responder.sv
// Top level of the READ TOC responder: front end, command queue and back end.
// Depends on crt_pkg, crt_channels, crt_front, crt_queue, crt_back and the assertion header.
//
//   Channel  Direction  Beat
//   req_if   in         one READ TOC command (msf_format, track_requested, alloc_length)
//   rsp_if   out        one response byte, or one status item without data
//   csr_*    in         register write, no handshake
//
// A command answers with min(alloc_length, 12) beats, one per cycle while the sink is ready,
// or one beat on error or zero length.
// The byte emitter loads the next queued command in the cycle its last beat leaves,
// and the front end takes a command every cycle while the two-entry queue has room.
// MSF conversion runs in a three-stage pipeline next to the emitter, done before byte 9.
// Synchronous reset: control flops clear to zero, queue and output empty; no clearing pass.
`default_nettype none
`include "cd_read_toc_responder_assert.svh"
module cd_read_toc_responder (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [crt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [crt_pkg::CSR_DATA_W-1:0] csr_wdata,
   crt_req_if.sink                             req_if,
   crt_rsp_if.source                           rsp_if
);
   import crt_pkg::*;

   logic          push;
   cmd_type       push_cmd;
   logic          pop;
   cmd_type       head;
   q_stat_type    q_stat;
   back_mon_type  mon;

   // Accept and classify commands.
   crt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req_if),
      .q_stat    (q_stat),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   // Decoupling queue.
   crt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .q_stat   (q_stat)
   );

   // Convert and emit the response beats.
   crt_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .q_stat (q_stat),
      .pop    (pop),
      .rsp_if (rsp_if),
      .mon    (mon)
   );

   // The emitter never takes a command from an empty queue.
   `CRT_ASSERT_IMP(a_pop_not_empty, clock, reset, pop, !q_stat.empty, "pop from empty queue")
   // MSF address bytes are only emitted after the conversion has settled.
   `CRT_ASSERT_IMP(a_conv_ready, clock, reset, mon.emit && mon.msf && mon.addr_byte, mon.conv_ready, "MSF bytes before conversion done")
   // An error status always travels alone, without data, as the final beat.
   `CRT_ASSERT_IMP(a_err_alone, clock, reset, rsp_if.valid && (rsp_if.status != ST_GOOD), rsp_if.no_data && rsp_if.last, "error beat with data or not last")
   // After the last beat with nothing queued, the emitter goes idle.
   `CRT_ASSERT_NEXT(a_idle_after_last, clock, reset, mon.emit && mon.last && q_stat.empty && !push, !mon.busy, "emitter busy after last beat")

endmodule
`default_nettype wire

>>> rtl/core/crt_front.sv
// Front end: configuration registers, command acceptance and classification.
// Depends on crt_pkg and the request channel interface.
`default_nettype none
module crt_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [crt_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [crt_pkg::CSR_DATA_W-1:0] csr_wdata,
   crt_req_if.sink                            req_if,
   input  wire crt_pkg::q_stat_type           q_stat,
   output logic                               push,
   output crt_pkg::cmd_type                   push_cmd
);
   import crt_pkg::*;

   logic               unit_ready_ff, unit_ready_in;
   logic               track_set_up_ff, track_set_up_in;
   logic [BLOCK_W-1:0] first_block_ff, first_block_in;
   logic [BLOCK_W-1:0] final_block_ff, final_block_in;

   logic                     trk_all, trk_data, trk_lead;
   logic                     bad_track;
   logic [BLOCK_W-1:0]       base;
   logic [ADDR_W-1:0]        offset;

   // Register writes.
   always_comb begin
      unit_ready_in   = unit_ready_ff;
      track_set_up_in = track_set_up_ff;
      first_block_in  = first_block_ff;
      final_block_in  = final_block_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_UNIT_READY:   unit_ready_in   = csr_wdata[0];
            CSR_TRACK_SET_UP: track_set_up_in = csr_wdata[0];
            CSR_FIRST_BLOCK:  first_block_in  = csr_wdata;
            CSR_FINAL_BLOCK:  final_block_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ready_ff   <= 1'b0;
         track_set_up_ff <= 1'b0;
         first_block_ff  <= '0;
         final_block_ff  <= '0;
      end else begin
         unit_ready_ff   <= unit_ready_in;
         track_set_up_ff <= track_set_up_in;
         first_block_ff  <= first_block_in;
         final_block_ff  <= final_block_in;
      end
   end

   // A command is taken whenever the queue has room.
   assign req_if.ready = !q_stat.full;
   assign push         = req_if.valid && !q_stat.full;

   // Classify the command and pick the reported address.
   always_comb begin
      trk_all   = (req_if.track_requested == TRACK_ALL);
      trk_data  = (req_if.track_requested == TRACK_DATA);
      trk_lead  = (req_if.track_requested == TRACK_LEADOUT);
      bad_track = !(trk_all || trk_data || trk_lead) || (trk_data && !track_set_up_ff);

      push_cmd.leadout = trk_lead && !track_set_up_ff;
      push_cmd.msf     = req_if.msf_format;
      if (!unit_ready_ff) begin
         push_cmd.status = ST_NOT_READY;
      end else if (bad_track) begin
         push_cmd.status = ST_BAD_FIELD;
      end else begin
         push_cmd.status = ST_GOOD;
      end

      if (req_if.alloc_length >= ALLOC_W'(TOC_BYTES)) begin
         push_cmd.count = CNT_W'(TOC_BYTES);
      end else begin
         push_cmd.count = req_if.alloc_length[CNT_W-1:0];
      end
      push_cmd.empty = (push_cmd.status != ST_GOOD) || (req_if.alloc_length == '0);

      // Lead-out reports the block after the track; MSF form adds the base.
      base   = push_cmd.leadout ? final_block_ff : first_block_ff;
      offset = ADDR_W'(push_cmd.leadout) + (req_if.msf_format ? ADDR_W'(MSF_BASE) : '0);
      push_cmd.value = {1'b0, base} + offset;
   end

endmodule
`default_nettype wire

>>> rtl/core/crt_queue.sv
// Short command queue decoupling the front end from the byte emitter.
// Depends on crt_pkg for the command type and depth.
`default_nettype none
module crt_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire crt_pkg::cmd_type  push_cmd,
   input  wire logic              pop,
   output crt_pkg::cmd_type       head,
   output crt_pkg::q_stat_type    q_stat
);
   import crt_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign q_stat.full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (cnt_ff == '0);
   assign head         = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/crt_back.sv
// Back end: MSF conversion pipeline and the byte emitter with its output register.
// Depends on crt_pkg and the response channel interface.
`default_nettype none
module crt_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire crt_pkg::cmd_type     head,
   input  wire crt_pkg::q_stat_type  q_stat,
   output logic                      pop,
   crt_rsp_if.source                 rsp_if,
   output crt_pkg::back_mon_type     mon
);
   import crt_pkg::*;

   // Byte offsets within the table of contents.
   localparam logic [IDX_W-1:0] B_LEN_HI  = 4'd0;
   localparam logic [IDX_W-1:0] B_LEN_LO  = 4'd1;
   localparam logic [IDX_W-1:0] B_FIRST   = 4'd2;
   localparam logic [IDX_W-1:0] B_LAST    = 4'd3;
   localparam logic [IDX_W-1:0] B_RSVD0   = 4'd4;
   localparam logic [IDX_W-1:0] B_CTRL    = 4'd5;
   localparam logic [IDX_W-1:0] B_TRACK   = 4'd6;
   localparam logic [IDX_W-1:0] B_RSVD1   = 4'd7;
   localparam logic [IDX_W-1:0] B_ADDR0   = 4'd8;
   localparam logic [IDX_W-1:0] B_ADDR1   = 4'd9;
   localparam logic [IDX_W-1:0] B_ADDR2   = 4'd10;
   localparam logic [IDX_W-1:0] B_ADDR3   = 4'd11;
   localparam int CONV_STAGES = 3;
   localparam int CONV_W      = $clog2(CONV_STAGES + 1);
   localparam int P1_W        = ADDR_W + DIV75_MUL_W;
   localparam int P2_W        = Q75_W + DIV60_MUL_W;

   cmd_type                 cur_ff, cur_in;
   logic                    busy_ff, busy_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [CONV_W-1:0]       conv_ff, conv_in;

   logic [ADDR_W-1:0]       v1_ff;
   logic [P1_W-1:0]         p1_ff;
   logic [Q75_W-1:0]        q75;
   logic [Q75_W-1:0]        q75_ff;
   logic [P2_W-1:0]         p2_ff;
   logic [BYTE_W-1:0]       frm_ff;
   logic [BYTE_W-1:0]       min_ff;
   logic [BYTE_W-1:0]       sec_ff;
   logic [Q75_W-1:0]        min_full;

   logic                    out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]       out_byte_ff;
   logic                    out_last_ff;
   status_type              out_status_ff;
   logic                    out_nodata_ff;

   logic                    can_emit;
   logic                    is_last;
   logic [BYTE_W-1:0]       toc_byte;

   // Emit when a command is loaded and the output register is free.
   always_comb begin
      can_emit = busy_ff && (!out_valid_ff || rsp_if.ready);
      is_last  = cur_ff.empty || (idx_ff == IDX_W'(cur_ff.count - 1'b1));
      pop      = !q_stat.empty && (!busy_ff || (can_emit && is_last));
   end

   // Command sequencing: load from the queue, step through the bytes.
   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (pop) begin
         cur_in  = head;
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (can_emit && is_last) begin
         busy_in = 1'b0;
      end else if (can_emit) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   // Conversion stage counter; results are settled once it saturates.
   always_comb begin
      if (pop) begin
         conv_in = '0;
      end else if (conv_ff == CONV_W'(CONV_STAGES)) begin
         conv_in = conv_ff;
      end else begin
         conv_in = conv_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         conv_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         conv_ff <= conv_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // Stage 1: frames times the reciprocal of 75.
   // Stage 2: frame within second, and seconds times the reciprocal of 60.
   // Stage 3: minute and second within minute.
   assign q75      = p1_ff[P1_W-1 -: Q75_W];
   assign min_full = Q75_W'(p2_ff[P2_W-1:DIV60_SHIFT]);

   always_ff @(posedge clock) begin
      v1_ff  <= cur_ff.value;
      p1_ff  <= P1_W'(cur_ff.value) * P1_W'(DIV75_MUL);
      q75_ff <= q75;
      frm_ff <= BYTE_W'(v1_ff - ADDR_W'(q75) * ADDR_W'(FRAMES_PER_SEC));
      p2_ff  <= P2_W'(q75) * P2_W'(DIV60_MUL);
      min_ff <= p2_ff[DIV60_SHIFT +: BYTE_W];
      sec_ff <= BYTE_W'(q75_ff - min_full * Q75_W'(SECS_PER_MIN));
   end

   // Table byte at the current offset.
   always_comb begin
      case (idx_ff)
         B_LEN_HI: toc_byte = '0;
         B_LEN_LO: toc_byte = TOC_LENGTH;
         B_FIRST:  toc_byte = TRACK_DATA;
         B_LAST:   toc_byte = TRACK_DATA;
         B_RSVD0:  toc_byte = '0;
         B_CTRL:   toc_byte = CTRL_DATA;
         B_TRACK:  toc_byte = cur_ff.leadout ? TRACK_LEADOUT : TRACK_DATA;
         B_RSVD1:  toc_byte = '0;
         B_ADDR0:  toc_byte = '0;
         B_ADDR1:  toc_byte = cur_ff.msf ? min_ff : '0;
         B_ADDR2:  toc_byte = cur_ff.msf ? sec_ff : cur_ff.value[2*BYTE_W-1:BYTE_W];
         B_ADDR3:  toc_byte = cur_ff.msf ? frm_ff : cur_ff.value[BYTE_W-1:0];
         default:  toc_byte = '0;
      endcase
   end

   // Output register holds a beat until the sink takes it.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (can_emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (can_emit) begin
         out_byte_ff   <= cur_ff.empty ? '0 : toc_byte;
         out_last_ff   <= is_last;
         out_status_ff <= cur_ff.status;
         out_nodata_ff <= cur_ff.empty;
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.data_byte = out_byte_ff;
   assign rsp_if.last      = out_last_ff;
   assign rsp_if.status    = out_status_ff;
   assign rsp_if.no_data   = out_nodata_ff;

   // Status for checking.
   always_comb begin
      mon.busy       = busy_ff;
      mon.emit       = can_emit;
      mon.last       = is_last;
      mon.msf        = cur_ff.msf && !cur_ff.empty;
      mon.addr_byte  = (idx_ff >= B_ADDR1);
      mon.conv_ready = (conv_ff == CONV_W'(CONV_STAGES));
   end

endmodule
`default_nettype wire
